@@ rtl/core/bib_pkg.sv @@
// Shared types, codes and defaults of the backend instance balancer.
// No dependencies; every other file of the block but bib_ram imports this package.
`default_nettype none
package bib_pkg;

  localparam int unsigned SERVICES_DEF  = 32;
  localparam int unsigned INSTANCES_DEF = 64;

  localparam logic [2:0] CMD_REGISTER = 3'd0;
  localparam logic [2:0] CMD_UPDATE   = 3'd1;
  localparam logic [2:0] CMD_RESOLVE  = 3'd2;
  localparam logic [2:0] CMD_SELECT   = 3'd3;
  localparam logic [2:0] CMD_OPEN     = 3'd4;
  localparam logic [2:0] CMD_RELEASE  = 3'd5;

  localparam logic [1:0] POL_RR   = 2'd0;
  localparam logic [1:0] POL_RAND = 2'd1;
  localparam logic [1:0] POL_LR   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  service;
    logic [47:0] endpoint;
    logic        healthy;
    logic [1:0]  policy;
    logic [31:0] probe_seed;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  instance_res;
    logic [4:0]  new_service;
    logic [47:0] found_endpoint;
  } out_word_t;

  typedef struct packed {
    logic [47:0] endpoint;
    logic        healthy;
    logic [15:0] active;
  } inst_t;

  localparam int unsigned INST_W = $bits(inst_t);

  typedef enum logic [2:0] {
    SC_NONE,
    SC_UPD,
    SC_RES,
    SC_REL,
    SC_RR,
    SC_RND,
    SC_LR
  } scan_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOD,
    S_RD,
    S_CHK,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic init;
    logic mod_go;
    logic mod_ld;
    logic step;
    logic commit_hit;
    logic commit_end;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic imm;
    logic need_mod;
    logic hit;
    logic last;
    logic mod_done;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/backend_instance_balancer.sv @@
// Backend instance balancer: one word in, one result word out per command.
// Register, unknown service and bad commands go from accept through the execute state to output.
// Scanning commands add a read and a check state per probed instance, up to the service's count;
// the seeded policy first waits in the modulo state for the serial remainder unit.
// One command is in flight at a time; the instance RAM read is the probe loop.
// Reset clears the service count and control state; tables need no clearing pass.
`default_nettype none
module backend_instance_balancer #(
  parameter int unsigned SERVICES  = bib_pkg::SERVICES_DEF,
  parameter int unsigned INSTANCES = bib_pkg::INSTANCES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bib_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bib_pkg::out_word_t out_word_o
);
  import bib_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  bib_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  bib_datapath #(
    .SERVICES (SERVICES),
    .INSTANCES(INSTANCES)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_word_i (in_word_i),
    .cmd_i     (dp_cmd),
    .sts_o     (dp_sts),
    .out_word_o(out_word_o)
  );
endmodule
`default_nettype wire

@@ rtl/core/bib_ram.sv @@
// Generic single-port RAM with a registered read.
// No dependencies.
`default_nettype none
module bib_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ rtl/core/bib_mod.sv @@
// Bit-serial 32-bit remainder unit, one quotient bit per cycle.
// Depends on bib_pkg.
`default_nettype none
module bib_mod #(
  parameter int unsigned INSTANCES = bib_pkg::INSTANCES_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic [31:0]                              dividend_i,
  input  logic [$clog2(INSTANCES+1)-1:0]           divisor_i,
  output logic                                     done_o,
  output logic [(INSTANCES > 1 ? $clog2(INSTANCES) : 1)-1:0] rem_o
);
  import bib_pkg::*;
  localparam int unsigned CW = $clog2(INSTANCES + 1);
  localparam int unsigned IW = INSTANCES > 1 ? $clog2(INSTANCES) : 1;

  logic          busy_q;
  logic [4:0]    cnt_q;
  logic [31:0]   q_q;
  logic [CW-1:0] d_q;
  logic [CW-1:0] r_q;
  logic [CW:0]   t;
  logic [CW:0]   t_sub;

  assign t     = {r_q, q_q[31]};
  assign t_sub = t - {1'b0, d_q};
  assign rem_o = IW'(r_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      d_q <= divisor_i;
      r_q <= '0;
    end else if (busy_q) begin
      q_q <= {q_q[30:0], 1'b0};
      r_q <= (t >= {1'b0, d_q}) ? CW'(t_sub) : CW'(t);
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/bib_datapath.sv @@
// Datapath: service table, instance RAM, probe registers and result register.
// Depends on bib_pkg, bib_ram and bib_mod.
`default_nettype none
module bib_datapath #(
  parameter int unsigned SERVICES  = bib_pkg::SERVICES_DEF,
  parameter int unsigned INSTANCES = bib_pkg::INSTANCES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bib_pkg::in_word_t  in_word_i,
  input  bib_pkg::dp_cmd_t   cmd_i,
  output bib_pkg::dp_sts_t   sts_o,
  output bib_pkg::out_word_t out_word_o
);
  import bib_pkg::*;
  localparam int unsigned IW    = INSTANCES > 1 ? $clog2(INSTANCES) : 1;
  localparam int unsigned CW    = $clog2(INSTANCES + 1);
  localparam int unsigned SW    = SERVICES > 1 ? $clog2(SERVICES) : 1;
  localparam int unsigned SCW   = $clog2(SERVICES + 1);
  localparam int unsigned DEPTH = SERVICES * INSTANCES;
  localparam int unsigned AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  in_word_t      in_q;
  logic [SCW-1:0] svc_cnt_q;
  logic [1:0]    pol_q [SERVICES];
  logic [IW-1:0] rr_q [SERVICES];
  logic [CW-1:0] icnt_q [SERVICES];
  logic [CW-1:0] k_q;
  logic [IW-1:0] x_q;
  logic [31:0]   sum_q;
  logic          best_v_q;
  logic [IW-1:0] best_x_q;
  logic [16:0]   mn_q;
  logic [47:0]   best_ep_q;
  out_word_t     res_q;
  out_word_t     res_d;
  logic          res_ld;

  logic [SW-1:0] sidx;
  logic          known;
  logic          full;
  logic [CW-1:0] c;
  logic [1:0]    pol;
  scan_e         mode;
  logic [AW-1:0] base;
  logic [AW-1:0] reg_base;
  logic [INST_W-1:0] ram_rdata;
  inst_t         rd;
  logic          hit;
  logic          better;
  logic          fin_v;
  logic [IW-1:0] fin_x;
  logic [47:0]   fin_ep;
  logic [15:0]   fin_act;
  logic [CW-1:0] x_plus;
  logic [IW-1:0] x_inc;
  logic [IW-1:0] x_nx;
  logic          we;
  logic [AW-1:0] waddr;
  inst_t         wdata;
  logic [AW-1:0] ram_addr;
  logic          reg_we;
  logic          rr_we;
  logic          cnt_inc;
  logic          mod_done;
  logic [IW-1:0] mod_rem;

  assign sidx     = SW'(in_q.service);
  assign known    = 32'(in_q.service) < 32'(svc_cnt_q);
  assign full     = 32'(svc_cnt_q) >= 32'(SERVICES);
  assign c        = icnt_q[sidx];
  assign pol      = pol_q[sidx];
  assign base     = AW'(sidx) * AW'(INSTANCES);
  assign reg_base = AW'(svc_cnt_q) * AW'(INSTANCES);
  assign rd       = inst_t'(ram_rdata);
  assign better   = rd.healthy && ({1'b0, rd.active} < mn_q);
  assign x_plus   = CW'(x_q) + CW'(1);
  assign x_inc    = (x_plus == c) ? '0 : IW'(x_plus);
  assign x_nx     = (mode == SC_RND && sum_q == 32'hFFFF_FFFF) ? '0 : x_inc;

  always_comb begin
    mode = SC_NONE;
    if (in_q.command != CMD_REGISTER && known) begin
      unique case (in_q.command)
        CMD_UPDATE:  mode = SC_UPD;
        CMD_RESOLVE: mode = SC_RES;
        CMD_RELEASE: mode = SC_REL;
        CMD_SELECT, CMD_OPEN: begin
          unique case (pol)
            POL_RR:   mode = SC_RR;
            POL_RAND: mode = SC_RND;
            POL_LR:   mode = SC_LR;
            default:  mode = SC_NONE;
          endcase
        end
        default: mode = SC_NONE;
      endcase
    end
  end

  always_comb begin
    unique case (mode)
      SC_UPD:              hit = (rd.endpoint == in_q.endpoint);
      SC_RES, SC_RR, SC_RND: hit = rd.healthy;
      SC_REL:              hit = (rd.active != 16'd0);
      default:             hit = 1'b0;
    endcase
  end

  always_comb begin
    if (better) begin
      fin_v   = 1'b1;
      fin_x   = x_q;
      fin_ep  = rd.endpoint;
      fin_act = rd.active;
    end else begin
      fin_v   = best_v_q;
      fin_x   = best_x_q;
      fin_ep  = best_ep_q;
      fin_act = mn_q[15:0];
    end
  end

  always_comb begin
    we      = 1'b0;
    waddr   = base + AW'(x_q);
    wdata   = rd;
    res_ld  = 1'b0;
    res_d   = '0;
    res_d.status = ST_MISS;
    reg_we  = 1'b0;
    rr_we   = 1'b0;
    cnt_inc = 1'b0;
    if (cmd_i.init && mode == SC_NONE) begin
      res_ld = 1'b1;
      if (in_q.command == CMD_REGISTER) begin
        if (full) begin
          res_d.status = ST_FULL;
        end else begin
          reg_we = 1'b1;
          we     = 1'b1;
          waddr  = reg_base;
          wdata  = '{endpoint: in_q.endpoint, healthy: 1'b1, active: 16'd0};
          res_d.status      = ST_OK;
          res_d.new_service = 5'(svc_cnt_q);
        end
      end
    end else if (cmd_i.commit_hit) begin
      res_ld = 1'b1;
      res_d.status       = ST_OK;
      res_d.instance_res = 6'(x_q);
      unique case (mode)
        SC_UPD: begin
          we            = 1'b1;
          wdata.healthy = in_q.healthy;
        end
        SC_REL: begin
          we           = 1'b1;
          wdata.active = rd.active - 16'd1;
        end
        SC_RES: res_d.found_endpoint = rd.endpoint;
        default: begin
          res_d.found_endpoint = rd.endpoint;
          rr_we = (mode == SC_RR);
          if (in_q.command == CMD_OPEN && rd.active != CNT_MAX) begin
            we           = 1'b1;
            wdata.active = rd.active + 16'd1;
          end
        end
      endcase
    end else if (cmd_i.commit_end) begin
      res_ld = 1'b1;
      if (mode == SC_UPD) begin
        if (32'(c) < 32'(INSTANCES)) begin
          we      = 1'b1;
          cnt_inc = 1'b1;
          waddr   = base + AW'(c);
          wdata   = '{endpoint: in_q.endpoint, healthy: in_q.healthy, active: 16'd0};
          res_d.status       = ST_OK;
          res_d.instance_res = 6'(c);
        end else begin
          res_d.status = ST_FULL;
        end
      end else if (mode == SC_LR && fin_v) begin
        res_d.status         = ST_OK;
        res_d.instance_res   = 6'(fin_x);
        res_d.found_endpoint = fin_ep;
        if (in_q.command == CMD_OPEN && fin_act != CNT_MAX) begin
          we    = 1'b1;
          waddr = base + AW'(fin_x);
          wdata = '{endpoint: fin_ep, healthy: 1'b1, active: fin_act + 16'd1};
        end
      end
    end
  end

  assign ram_addr = we ? waddr : base + AW'(x_q);

  bib_ram #(
    .WIDTH(INST_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (ram_addr),
    .wdata_i(wdata),
    .rdata_o(ram_rdata)
  );

  bib_mod #(
    .INSTANCES(INSTANCES)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mod_go),
    .dividend_i(in_q.probe_seed),
    .divisor_i (c),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      svc_cnt_q <= '0;
    end else if (reg_we) begin
      svc_cnt_q <= svc_cnt_q + SCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_word_i;
    end
    if (reg_we) begin
      pol_q[SW'(svc_cnt_q)]  <= in_q.policy;
      rr_q[SW'(svc_cnt_q)]   <= '0;
      icnt_q[SW'(svc_cnt_q)] <= CW'(1);
    end
    if (rr_we) begin
      rr_q[sidx] <= x_inc;
    end
    if (cnt_inc) begin
      icnt_q[sidx] <= c + CW'(1);
    end
    if (cmd_i.init) begin
      k_q      <= '0;
      x_q      <= (mode == SC_RR) ? rr_q[sidx] : '0;
      sum_q    <= in_q.probe_seed;
      best_v_q <= 1'b0;
      mn_q     <= '1;
    end else if (cmd_i.mod_ld) begin
      x_q <= mod_rem;
    end else if (cmd_i.step) begin
      k_q   <= k_q + CW'(1);
      x_q   <= x_nx;
      sum_q <= sum_q + 32'd1;
      if (mode == SC_LR && better) begin
        best_v_q  <= 1'b1;
        best_x_q  <= x_q;
        mn_q      <= {1'b0, rd.active};
        best_ep_q <= rd.endpoint;
      end
    end
    if (res_ld) begin
      res_q <= res_d;
    end
    if (cmd_i.emit) begin
      out_word_o <= res_q;
    end
  end

  assign sts_o.imm      = (mode == SC_NONE);
  assign sts_o.need_mod = (mode == SC_RND);
  assign sts_o.hit      = hit;
  assign sts_o.last     = ({1'b0, k_q} + (CW + 1)'(1)) >= {1'b0, c};
  assign sts_o.mod_done = mod_done;
endmodule
`default_nettype wire

@@ rtl/core/bib_ctrl.sv @@
// Controller state machine: handshakes and sequencing of the probe loop.
// Depends on bib_pkg.
`default_nettype none
module bib_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  bib_pkg::dp_sts_t sts_i,
  output bib_pkg::dp_cmd_t cmd_o
);
  import bib_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.init = 1'b1;
        if (sts_i.imm) begin
          state_d = S_OUT;
        end else if (sts_i.need_mod) begin
          cmd_o.mod_go = 1'b1;
          state_d      = S_MOD;
        end else begin
          state_d = S_RD;
        end
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          cmd_o.mod_ld = 1'b1;
          state_d      = S_RD;
        end
      end
      S_RD: state_d = S_CHK;
      S_CHK: begin
        priority if (sts_i.hit) begin
          cmd_o.commit_hit = 1'b1;
          state_d          = S_OUT;
        end else if (sts_i.last) begin
          cmd_o.commit_end = 1'b1;
          state_d          = S_OUT;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_RD;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire
